// ----- hdl/omd_pkg.sv -----
`timescale 1ns / 1ps

package omd_pkg;

   // Sine magnitude precision and derived widths
   localparam int SINE_FRAC_BITS = 15;
   localparam int MAG_W          = SINE_FRAC_BITS + 1;
   localparam int SINE_SHIFT     = 30 - SINE_FRAC_BITS;

   localparam int WHEELS    = 3;
   localparam int ANGLE_W   = 9;
   localparam int HEADING_W = 11;
   localparam int POWER_W   = 8;
   localparam int K_W       = 7;
   localparam int SUM_W     = 13;
   localparam int FOLD_W    = 12;

   localparam int FULL_TURN     = 360;
   localparam int HALF_TURN     = 180;
   localparam int QUARTER_TURN  = 90;
   localparam int THREE_QUARTER = 270;
   localparam int ANGLE_BIAS    = 4 * FULL_TURN;

   // Divider: numerator 2*fs*mag + max, denominator 2*max
   localparam int NUM_W     = MAG_W + POWER_W + 1;
   localparam int DEN_W     = MAG_W + 1;
   localparam int DIV_STEPS = POWER_W;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 9;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_FR_ANGLE   = 2'd0,
      CSR_BACK_ANGLE = 2'd1,
      CSR_FL_ANGLE   = 2'd2,
      CSR_FULL_SCALE = 2'd3
   } csr_index_type;

   typedef logic [MAG_W-1:0] mag_type;
   typedef logic [QUARTER_TURN:0][MAG_W-1:0] sine_lut_type;

   typedef struct packed {
      logic [WHEELS-1:0][ANGLE_W-1:0] angle;
      logic [POWER_W-1:0]             full_scale;
   } cfg_type;

   typedef struct packed {
      logic [WHEELS-1:0]             rev;
      logic [WHEELS-1:0][MAG_W-1:0] mag;
   } item_type;

   typedef struct packed {
      logic [WHEELS-1:0]               rev;
      logic [WHEELS-1:0][POWER_W-1:0] power;
   } result_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   localparam logic [63:0] PI_Q60  = 64'h3243F6A8885A308D;
   localparam logic [63:0] PI_STEP = PI_Q60 / 64'd180;
   localparam logic [63:0] ONE_Q30 = 64'd1 << 30;
   localparam logic [63:0] HALF_Q30 = 64'd1 << 29;

   // shift-and-subtract quotient, elaboration only
   function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
      logic [63:0] rem, quo;
      rem = 64'd0;
      quo = 64'd0;
      for (int i = 63; i >= 0; i--) begin
         rem = {rem[62:0], num[i]};
         if (rem >= den) begin
            rem    = rem - den;
            quo[i] = 1'b1;
         end
      end
      return quo;
   endfunction

   // sin(k deg) in Q2.30 by series, evaluated at elaboration only
   function automatic logic [63:0] sine_q30(input int unsigned k);
      logic [63:0] x, x2, term, sum_pos, sum_neg, den;
      int unsigned n;
      x = ((PI_STEP * 64'(k)) + HALF_Q30) >> 30;
      x2 = ((x * x) + HALF_Q30) >> 30;
      term = x;
      sum_pos = x;
      sum_neg = 64'd0;
      for (n = 1; n <= 10; n++) begin
         den = 64'(2 * n) * 64'(2 * n + 1);
         term = udiv64((term * x2) + (den >> 1), den);
         term = (term + HALF_Q30) >> 30;
         if (n[0]) begin
            sum_neg = sum_neg + term;
         end else begin
            sum_pos = sum_pos + term;
         end
      end
      if (sum_neg >= sum_pos) begin
         return 64'd0;
      end
      sum_pos = sum_pos - sum_neg;
      if (sum_pos > ONE_Q30) begin
         sum_pos = ONE_Q30;
      end
      return sum_pos;
   endfunction

   function automatic sine_lut_type build_sine_lut();
      sine_lut_type lut;
      logic [63:0]  s30;
      int unsigned  k;
      for (k = 0; k <= QUARTER_TURN; k++) begin
         s30 = sine_q30(k);
         lut[k] = MAG_W'((s30 + (64'd1 << (SINE_SHIFT - 1))) >> SINE_SHIFT);
      end
      return lut;
   endfunction

   localparam sine_lut_type SINE_LUT = build_sine_lut();

endpackage

// ----- hdl/omni_wheel_drive_mixer_core.sv -----
`timescale 1ns / 1ps

// Three-wheel omni drive mixer. Each req beat carries a signed heading in
// degrees; each rsp beat gives, per wheel, a power in 0..full_scale and a
// reverse bit, the wheel with the largest sine magnitude getting full_scale.
// One heading is taken per clock unless the queue is full, and results
// come out in order. A beat passes the angle fold and sine lookup
// registers, the 4-entry queue, the max and multiply registers, then the
// divider, one quotient bit per stage. A stalled rsp side holds the back
// pipeline only; the front keeps taking beats until the queue fills.
// The user writes mounting angles and full_scale via the csr port while
// no beat is in flight (not enforced by the block); angles above 359 wrap.

module omni_wheel_drive_mixer_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [15:0]                        req_tdata,  // [10:0] heading_deg
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [7:0] front_right_power, [8] front_right_reverse, [16:9] back_power,
   // [17] back_reverse, [25:18] front_left_power, [26] front_left_reverse
   output logic [31:0]                        rsp_tdata,
   input  logic                               csr_wen,
   input  logic [omd_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  logic [omd_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import omd_pkg::*;

   cfg_type          cfg_ff, cfg_in;
   queue_status_type q_status;
   logic             push, pop;
   item_type         push_item, head_item;
   result_type       result;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wen) begin
         case (csr_addr)
            CSR_FR_ANGLE:   cfg_in.angle[0]   = csr_wdata[ANGLE_W-1:0];
            CSR_BACK_ANGLE: cfg_in.angle[1]   = csr_wdata[ANGLE_W-1:0];
            CSR_FL_ANGLE:   cfg_in.angle[2]   = csr_wdata[ANGLE_W-1:0];
            CSR_FULL_SCALE: cfg_in.full_scale = csr_wdata[POWER_W-1:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.angle[0]   <= ANGLE_W'(60);
         cfg_ff.angle[1]   <= ANGLE_W'(180);
         cfg_ff.angle[2]   <= ANGLE_W'(300);
         cfg_ff.full_scale <= POWER_W'(100);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   omd_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .heading_deg (req_tdata[HEADING_W-1:0]),
      .cfg         (cfg_ff),
      .q_status    (q_status),
      .push        (push),
      .push_item   (push_item)
   );

   omd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .pop_item  (head_item),
      .status    (q_status)
   );

   omd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_status   (q_status),
      .head_item  (head_item),
      .pop        (pop),
      .full_scale (cfg_ff.full_scale),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .result     (result)
   );

   assign rsp_tdata = {5'b0,
                       result.rev[2], result.power[2],
                       result.rev[1], result.power[1],
                       result.rev[0], result.power[0]};

endmodule

// ----- hdl/omd_front.sv -----
`timescale 1ns / 1ps

module omd_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic signed [omd_pkg::HEADING_W-1:0] heading_deg,
   input  omd_pkg::cfg_type                  cfg,
   input  omd_pkg::queue_status_type         q_status,
   output logic                              push,
   output omd_pkg::item_type                 push_item
);
   import omd_pkg::*;

   logic                            advance;
   logic                            f1_valid_ff, f1_valid_in;
   logic                            f2_valid_ff, f2_valid_in;
   logic [WHEELS-1:0][ANGLE_W-1:0] f1_angle_ff, f1_angle_in;
   item_type                        f2_item_ff, f2_item_in;

   assign advance    = !f2_valid_ff || !q_status.full;
   assign req_tready = advance;
   assign push       = f2_valid_ff && !q_status.full;
   assign push_item  = f2_item_ff;

   assign f1_valid_in = req_tvalid;
   assign f2_valid_in = f1_valid_ff;

   // wheel angle = (heading - mount) mod 360, biased positive then folded
   always_comb begin
      logic [ANGLE_W-1:0]     mount;
      logic [SUM_W-1:0]       sum;
      logic [FOLD_W-1:0]      v;
      for (int w = 0; w < WHEELS; w++) begin
         mount = cfg.angle[w];
         if (mount >= ANGLE_W'(FULL_TURN)) begin
            mount = mount - ANGLE_W'(FULL_TURN);
         end
         sum = SUM_W'(ANGLE_BIAS) + SUM_W'(heading_deg) - SUM_W'(mount);
         v = sum[FOLD_W-1:0];
         if (v >= FOLD_W'(4 * FULL_TURN)) begin
            v = v - FOLD_W'(4 * FULL_TURN);
         end
         if (v >= FOLD_W'(2 * FULL_TURN)) begin
            v = v - FOLD_W'(2 * FULL_TURN);
         end
         if (v >= FOLD_W'(FULL_TURN)) begin
            v = v - FOLD_W'(FULL_TURN);
         end
         f1_angle_in[w] = v[ANGLE_W-1:0];
      end
   end

   // quadrant fold and table lookup
   always_comb begin
      logic [ANGLE_W-1:0] a;
      logic [ANGLE_W-1:0] k;
      mag_type            mag;
      for (int w = 0; w < WHEELS; w++) begin
         a = f1_angle_ff[w];
         if (a inside {[0:QUARTER_TURN]}) begin
            k = a;
         end else if (a inside {[QUARTER_TURN+1:HALF_TURN]}) begin
            k = ANGLE_W'(HALF_TURN) - a;
         end else if (a inside {[HALF_TURN+1:THREE_QUARTER]}) begin
            k = a - ANGLE_W'(HALF_TURN);
         end else begin
            k = ANGLE_W'(FULL_TURN) - a;
         end
         mag = SINE_LUT[k[K_W-1:0]];
         f2_item_in.mag[w] = mag;
         f2_item_in.rev[w] = (a > ANGLE_W'(HALF_TURN)) && (mag != '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_valid_ff <= 1'b0;
         f2_valid_ff <= 1'b0;
      end else if (advance) begin
         f1_valid_ff <= f1_valid_in;
         f2_valid_ff <= f2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         f1_angle_ff <= f1_angle_in;
         f2_item_ff  <= f2_item_in;
      end
   end

endmodule

// ----- hdl/omd_queue.sv -----
`timescale 1ns / 1ps

module omd_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  omd_pkg::item_type         push_item,
   input  logic                      pop,
   output omd_pkg::item_type         pop_item,
   output omd_pkg::queue_status_type status
);
   import omd_pkg::*;

   item_type            entries_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                do_push, do_pop;

   assign status.full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign pop_item     = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ----- hdl/omd_back.sv -----
`timescale 1ns / 1ps

module omd_back (
   input  logic                          clock,
   input  logic                          reset,
   input  omd_pkg::queue_status_type     q_status,
   input  omd_pkg::item_type             head_item,
   output logic                          pop,
   input  logic [omd_pkg::POWER_W-1:0]   full_scale,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output omd_pkg::result_type           result
);
   import omd_pkg::*;

   logic advance;

   // B0: item plus largest magnitude
   logic      b0_valid_ff, b0_valid_in;
   item_type  b0_item_ff;
   mag_type   b0_max_ff, b0_max_in;

   // B1: numerators and shared denominator
   logic                          b1_valid_ff;
   logic [WHEELS-1:0]             b1_rev_ff;
   logic [WHEELS-1:0][NUM_W-1:0] b1_num_ff, b1_num_in;
   logic [DEN_W-1:0]              b1_den_ff, b1_den_in;

   // restoring divide, one quotient bit per stage
   logic                          dv_valid_ff [DIV_STEPS];
   logic [WHEELS-1:0]             dv_rev_ff   [DIV_STEPS];
   logic [DEN_W-1:0]              dv_den_ff   [DIV_STEPS];
   logic [WHEELS-1:0][NUM_W-1:0] dv_rem_ff   [DIV_STEPS];
   logic [WHEELS-1:0][POWER_W-1:0] dv_quo_ff [DIV_STEPS];

   logic                          src_valid [DIV_STEPS];
   logic [WHEELS-1:0]             src_rev   [DIV_STEPS];
   logic [DEN_W-1:0]              src_den   [DIV_STEPS];
   logic [WHEELS-1:0][NUM_W-1:0] src_rem   [DIV_STEPS];
   logic [WHEELS-1:0][POWER_W-1:0] src_quo [DIV_STEPS];

   logic [WHEELS-1:0][NUM_W-1:0]   dv_rem_in [DIV_STEPS];
   logic [WHEELS-1:0][POWER_W-1:0] dv_quo_in [DIV_STEPS];

   assign advance     = !rsp_tvalid || rsp_tready;
   assign pop         = advance && !q_status.empty;
   assign b0_valid_in = !q_status.empty;

   always_comb begin
      b0_max_in = head_item.mag[0];
      if (head_item.mag[1] > b0_max_in) begin
         b0_max_in = head_item.mag[1];
      end
      if (head_item.mag[2] > b0_max_in) begin
         b0_max_in = head_item.mag[2];
      end
   end

   // all-zero sines: numerators are zero, a unit denominator gives zero power
   always_comb begin
      for (int w = 0; w < WHEELS; w++) begin
         b1_num_in[w] = NUM_W'({full_scale, 1'b0}) * NUM_W'(b0_item_ff.mag[w])
                        + NUM_W'(b0_max_ff);
      end
      if (b0_max_ff == '0) begin
         b1_den_in = DEN_W'(1);
      end else begin
         b1_den_in = {b0_max_ff, 1'b0};
      end
   end

   for (genvar s = 0; s < DIV_STEPS; s++) begin : g_src
      if (s == 0) begin : g_first
         assign src_valid[s] = b1_valid_ff;
         assign src_rev[s]   = b1_rev_ff;
         assign src_den[s]   = b1_den_ff;
         assign src_rem[s]   = b1_num_ff;
         assign src_quo[s]   = '0;
      end else begin : g_next
         assign src_valid[s] = dv_valid_ff[s-1];
         assign src_rev[s]   = dv_rev_ff[s-1];
         assign src_den[s]   = dv_den_ff[s-1];
         assign src_rem[s]   = dv_rem_ff[s-1];
         assign src_quo[s]   = dv_quo_ff[s-1];
      end
   end

   always_comb begin
      logic [NUM_W-1:0] dshift;
      for (int s = 0; s < DIV_STEPS; s++) begin
         dshift = NUM_W'(src_den[s]) << (DIV_STEPS - 1 - s);
         for (int w = 0; w < WHEELS; w++) begin
            if (src_rem[s][w] >= dshift) begin
               dv_rem_in[s][w] = src_rem[s][w] - dshift;
               dv_quo_in[s][w] = {src_quo[s][w][POWER_W-2:0], 1'b1};
            end else begin
               dv_rem_in[s][w] = src_rem[s][w];
               dv_quo_in[s][w] = {src_quo[s][w][POWER_W-2:0], 1'b0};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b0_valid_ff <= 1'b0;
         b1_valid_ff <= 1'b0;
         for (int s = 0; s < DIV_STEPS; s++) begin
            dv_valid_ff[s] <= 1'b0;
         end
      end else if (advance) begin
         b0_valid_ff <= b0_valid_in;
         b1_valid_ff <= b0_valid_ff;
         for (int s = 0; s < DIV_STEPS; s++) begin
            dv_valid_ff[s] <= src_valid[s];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         b0_item_ff <= head_item;
         b0_max_ff  <= b0_max_in;
         b1_rev_ff  <= b0_item_ff.rev;
         b1_num_ff  <= b1_num_in;
         b1_den_ff  <= b1_den_in;
         for (int s = 0; s < DIV_STEPS; s++) begin
            dv_rev_ff[s] <= src_rev[s];
            dv_den_ff[s] <= src_den[s];
            dv_rem_ff[s] <= dv_rem_in[s];
            dv_quo_ff[s] <= dv_quo_in[s];
         end
      end
   end

   assign rsp_tvalid   = dv_valid_ff[DIV_STEPS-1];
   assign result.rev   = dv_rev_ff[DIV_STEPS-1];
   assign result.power = dv_quo_ff[DIV_STEPS-1];

endmodule

// ----- dv/omd_mixer_checker.sv -----
`timescale 1ns / 1ps

module omd_mixer_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   input  logic                           req_tready,
   input  logic [15:0]                    req_tdata,   // [10:0] heading_deg
   input  logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // [7:0] fr power, [8] fr reverse, [16:9] back power, [17] back reverse,
   // [25:18] fl power, [26] fl reverse
   input  logic [31:0]                    rsp_tdata,
   input  logic                           csr_wen,
   input  logic [omd_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [omd_pkg::CSR_DATA_W-1:0] csr_wdata,
   output int                             fail_count,
   output int                             pending_count
);
   import omd_pkg::*;

   localparam int ROUND_SHIFT = 30 - SINE_FRAC_BITS;

   // one wheel occupies 9 bits: power then reverse
   typedef struct packed {
      logic [HEADING_W-1:0] heading;
      logic [26:0]          cmd;
   } drive_beat_type;

   logic [MAG_W-1:0]   quarter_sine [0:QUARTER_TURN];
   logic [ANGLE_W-1:0] mount [WHEELS];
   logic [POWER_W-1:0] scale;
   drive_beat_type     drive_expected_q [$];
   drive_beat_type     want;
   int                 mismatches = 0;
   int                 w;
   string              wheel_label [WHEELS] = '{"front_right", "back", "front_left"};

   // sin(deg) in Q2.30 on 0..90 by an eleven-term series
   function automatic logic [63:0] series_sin_q30(input int unsigned deg);
      logic [63:0] pi_q60, x, x2, term, pos, neg, den;
      int unsigned n;
      pi_q60 = 64'h3243F6A8885A308D;
      x = (((pi_q60 / 64'd180) * 64'(deg)) + (64'd1 << 29)) >> 30;
      x2 = ((x * x) + (64'd1 << 29)) >> 30;
      term = x;
      pos = x;
      neg = 64'd0;
      for (n = 1; n <= 10; n++) begin
         den = 64'(2 * n) * 64'(2 * n + 1);
         term = ((term * x2) + (den / 64'd2)) / den;
         term = (term + (64'd1 << 29)) >> 30;
         if (n % 2 == 1) begin
            neg = neg + term;
         end else begin
            pos = pos + term;
         end
      end
      if (neg >= pos) begin
         return 64'd0;
      end
      pos = pos - neg;
      if (pos > (64'd1 << 30)) begin
         pos = 64'd1 << 30;
      end
      return pos;
   endfunction

   function automatic logic [26:0] mix_heading(input logic [HEADING_W-1:0] raw);
      int          h, m, d, k;
      logic [63:0] mag [WHEELS];
      logic        negative [WHEELS];
      logic [63:0] peak, pw;
      logic [26:0] r;
      h = int'($signed(raw));
      peak = 64'd0;
      r = '0;
      for (int i = 0; i < WHEELS; i++) begin
         m = int'(mount[i]);
         m = m % FULL_TURN;
         d = (h - m) % FULL_TURN;
         if (d < 0) begin
            d = d + FULL_TURN;
         end
         if (d <= QUARTER_TURN) begin
            k = d;
         end else if (d <= HALF_TURN) begin
            k = HALF_TURN - d;
         end else if (d <= THREE_QUARTER) begin
            k = d - HALF_TURN;
         end else begin
            k = FULL_TURN - d;
         end
         negative[i] = (d > HALF_TURN);
         mag[i] = 64'(quarter_sine[k]);
         if (mag[i] > peak) begin
            peak = mag[i];
         end
      end
      for (int i = 0; i < WHEELS; i++) begin
         pw = 64'd0;
         if (peak != 64'd0) begin
            pw = (64'd2 * 64'(scale) * mag[i] + peak) / (64'd2 * peak);
         end
         r[9*i +: 8] = pw[7:0];
         r[9*i + 8]  = negative[i] && (mag[i] != 64'd0);
      end
      return r;
   endfunction

   initial begin
      for (int k = 0; k <= QUARTER_TURN; k++) begin
         quarter_sine[k] = MAG_W'((series_sin_q30(k) + (64'd1 << (ROUND_SHIFT - 1)))
                                  >> ROUND_SHIFT);
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         mount[0] = 9'd60;
         mount[1] = 9'd180;
         mount[2] = 9'd300;
         scale = 8'd100;
         drive_expected_q.delete();
         fail_count <= 0;
         pending_count <= 0;
      end else begin
         if (csr_wen) begin
            case (csr_addr)
               CSR_FR_ANGLE:   mount[0] = csr_wdata;
               CSR_BACK_ANGLE: mount[1] = csr_wdata;
               CSR_FL_ANGLE:   mount[2] = csr_wdata;
               CSR_FULL_SCALE: scale = csr_wdata[POWER_W-1:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            drive_expected_q.push_back({req_tdata[HEADING_W-1:0],
                                        mix_heading(req_tdata[HEADING_W-1:0])});
         end
         if (rsp_tvalid && rsp_tready) begin
            if (drive_expected_q.size() == 0) begin
               $display("%0t: unexpected rsp beat, expected none actual %h",
                        $time, rsp_tdata);
               mismatches++;
            end else begin
               want = drive_expected_q.pop_front();
               for (w = 0; w < WHEELS; w++) begin
                  if (rsp_tdata[9*w +: 8] !== want.cmd[9*w +: 8]) begin
                     $display("%0t: heading %0d %s_power expected %0d actual %0d",
                              $time, $signed(want.heading), wheel_label[w],
                              want.cmd[9*w +: 8], rsp_tdata[9*w +: 8]);
                     mismatches++;
                  end
                  if (rsp_tdata[9*w + 8] !== want.cmd[9*w + 8]) begin
                     $display("%0t: heading %0d %s_reverse expected %0b actual %0b",
                              $time, $signed(want.heading), wheel_label[w],
                              want.cmd[9*w + 8], rsp_tdata[9*w + 8]);
                     mismatches++;
                  end
               end
            end
         end
         fail_count <= mismatches;
         pending_count <= drive_expected_q.size();
      end
   end

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
   import omd_pkg::*;

   localparam int QUIET_LIMIT  = 3000;
   localparam int SETTLE       = 16;
   localparam int LONG_HOLD    = 200;
   localparam int RANDOM_ITEMS = 108;

   logic                  clock;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [15:0]           req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [31:0]           rsp_tdata;
   logic                  csr_wen = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;
   int                    fail_count;
   int                    pending_count;

   logic [HEADING_W-1:0]  heading_fifo [$];
   int                    burst_left = 0;
   int                    gap_left = 0;
   int                    rx_mode = 0;
   int                    rx_mode_left = 0;
   int                    rx_tick = 0;
   int                    hold_left = 0;
   logic                  hold_arm = 1'b0;
   logic                  hold_taken = 1'b0;
   int                    quiet_cycles = 0;

   omni_wheel_drive_mixer_core DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wen    (csr_wen),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   omd_mixer_checker mixer_check (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .csr_wen       (csr_wen),
      .csr_addr      (csr_addr),
      .csr_wdata     (csr_wdata),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // heading beats in bursts, random gaps between them
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata <= '0;
      end else if (!req_tvalid || req_tready) begin
         if (gap_left > 0) begin
            gap_left--;
            req_tvalid <= 1'b0;
         end else if (heading_fifo.size() != 0) begin
            req_tvalid <= 1'b1;
            req_tdata <= {5'b0, heading_fifo.pop_front()};
            if (burst_left > 1) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(1, 40);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            end
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // rsp side: shifting stall patterns, plus one long hold-off once armed
   always @(posedge clock) begin
      rx_tick++;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (hold_arm && !hold_taken) begin
         hold_taken = 1'b1;
         hold_left = LONG_HOLD;
         rsp_tready <= 1'b0;
      end else begin
         if (rx_mode_left == 0) begin
            rx_mode = $urandom_range(0, 3);
            rx_mode_left = $urandom_range(20, 120);
         end
         rx_mode_left--;
         case (rx_mode)
            0: rsp_tready <= 1'b1;
            1: rsp_tready <= 1'($urandom_range(0, 1));
            2: rsp_tready <= (rx_tick % 5 < 3);
            default: rsp_tready <= ($urandom_range(0, 7) != 0);
         endcase
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("tb_top NOT OK");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic push_heading(input int h);
      heading_fifo.push_back(HEADING_W'(h));
   endtask

   task automatic push_random(input int n);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 3) == 0) begin
            push_heading(int'($urandom_range(0, 1439)) - 720);
         end else begin
            push_heading(int'($urandom_range(0, 2047)));
         end
      end
   endtask

   // everything sent and answered, then let the pipe run dry
   task automatic settle();
      do @(negedge clock);
      while (heading_fifo.size() != 0 || req_tvalid || pending_count != 0);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_config(input logic [CSR_DATA_W-1:0] fr, bk, fl, fs);
      @(posedge clock);
      csr_wen <= 1'b1;
      csr_addr <= CSR_FR_ANGLE;
      csr_wdata <= fr;
      @(posedge clock);
      csr_addr <= CSR_BACK_ANGLE;
      csr_wdata <= bk;
      @(posedge clock);
      csr_addr <= CSR_FL_ANGLE;
      csr_wdata <= fl;
      @(posedge clock);
      csr_addr <= CSR_FULL_SCALE;
      csr_wdata <= fs;
      @(posedge clock);
      csr_wen <= 1'b0;
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // reset mounting, heading extremes and wrap
      push_heading(0);
      push_heading(90);
      push_heading(-90);
      push_heading(719);
      push_heading(-720);
      push_heading(1023);
      push_heading(-1024);
      push_heading(60);
      push_heading(240);
      push_heading(1);
      settle();

      // mounts on the 0/180 line: some headings zero every sine
      write_config(9'd0, 9'd180, 9'd360, 9'd255);
      push_heading(0);
      push_heading(180);
      push_heading(-180);
      push_heading(540);
      push_heading(90);
      push_heading(270);
      push_heading(45);
      settle();

      // zero full scale, mounts past 359
      write_config(9'd359, 9'd511, 9'd1, 9'd0);
      push_heading(100);
      push_heading(-359);
      push_heading(2);
      settle();

      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: write_config(9'd60, 9'd180, 9'd300, 9'd255);
            1: write_config(CSR_DATA_W'($urandom_range(0, 511)),
                            CSR_DATA_W'($urandom_range(0, 511)),
                            CSR_DATA_W'($urandom_range(0, 511)),
                            CSR_DATA_W'($urandom_range(0, 511)));
            2: write_config(9'd0, 9'd120, 9'd240, 9'd1);
            3: write_config(9'd359, 9'd511, 9'd0, 9'h1FF);
            4: write_config(CSR_DATA_W'($urandom_range(0, 359)),
                            CSR_DATA_W'($urandom_range(0, 359)),
                            CSR_DATA_W'($urandom_range(0, 359)),
                            CSR_DATA_W'($urandom_range(0, 255)));
            default: write_config(CSR_DATA_W'($urandom_range(0, 511)),
                                  CSR_DATA_W'($urandom_range(0, 511)),
                                  CSR_DATA_W'($urandom_range(0, 511)),
                                  CSR_DATA_W'($urandom_range(0, 255)));
         endcase
         push_random(RANDOM_ITEMS);
         if (phase == 0) begin
            @(negedge clock);
            hold_arm = 1'b1;
         end
         settle();
      end

      repeat (SETTLE) @(posedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("tb_top OK");
      end else begin
         $display("tb_top NOT OK");
      end
      $finish;
   end

endmodule
